// File: rtl/assert_macros.svh
// Assertion macros used by mte_back; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLKED(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKED(label, clk, rst, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/mte_pkg.sv
`default_nettype none

package mte_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int SHOWN_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] EL_DIT        = 3'd0;
  localparam logic [2:0] EL_DAH        = 3'd1;
  localparam logic [2:0] EL_INTRA      = 3'd2;
  localparam logic [2:0] EL_INTER_SYM  = 3'd3;
  localparam logic [2:0] EL_INTER_WORD = 3'd4;
  localparam logic [2:0] EL_SKIPPED    = 3'd5;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_TOP     = 8'd95;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef struct packed {
    logic [7:0] character;
    logic       start_of_text;
  } text_t;

  typedef struct packed {
    logic [2:0]            element;
    logic                  last_of_run;
    logic [SHOWN_BITS-1:0] skipped_count;
  } elem_t;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_SPACE,
    KIND_SKIP
  } kind_t;

  // pattern holds the tones first-sent in the highest used bit, 1 for dah
  typedef struct packed {
    logic [2:0] len;
    logic [6:0] pattern;
  } rom_entry_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  inter_sym;
    logic [2:0]            len;
    logic [6:0]            pattern;
    logic [SHOWN_BITS-1:0] shown;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  function automatic rom_entry_t morse_rom(input logic [5:0] idx);
    logic [9:0] e;
    case (idx)
      6'd1:  e = {3'd6, 7'b0101011};
      6'd2:  e = {3'd6, 7'b0010010};
      6'd4:  e = {3'd7, 7'b0001001};
      6'd6:  e = {3'd5, 7'b0001000};
      6'd7:  e = {3'd6, 7'b0011110};
      6'd8:  e = {3'd5, 7'b0010110};
      6'd9:  e = {3'd6, 7'b0101101};
      6'd11: e = {3'd5, 7'b0001010};
      6'd12: e = {3'd6, 7'b0110011};
      6'd13: e = {3'd6, 7'b0100001};
      6'd14: e = {3'd6, 7'b0010101};
      6'd15: e = {3'd5, 7'b0010010};
      6'd16: e = {3'd5, 7'b0011111};
      6'd17: e = {3'd5, 7'b0001111};
      6'd18: e = {3'd5, 7'b0000111};
      6'd19: e = {3'd5, 7'b0000011};
      6'd20: e = {3'd5, 7'b0000001};
      6'd21: e = {3'd5, 7'b0000000};
      6'd22: e = {3'd5, 7'b0010000};
      6'd23: e = {3'd5, 7'b0011000};
      6'd24: e = {3'd5, 7'b0011100};
      6'd25: e = {3'd5, 7'b0011110};
      6'd26: e = {3'd6, 7'b0111000};
      6'd27: e = {3'd6, 7'b0101010};
      6'd29: e = {3'd5, 7'b0010001};
      6'd31: e = {3'd6, 7'b0001100};
      6'd32: e = {3'd6, 7'b0011010};
      6'd33: e = {3'd2, 7'b0000001};
      6'd34: e = {3'd4, 7'b0001000};
      6'd35: e = {3'd4, 7'b0001010};
      6'd36: e = {3'd3, 7'b0000100};
      6'd37: e = {3'd1, 7'b0000000};
      6'd38: e = {3'd4, 7'b0000010};
      6'd39: e = {3'd3, 7'b0000110};
      6'd40: e = {3'd4, 7'b0000000};
      6'd41: e = {3'd2, 7'b0000000};
      6'd42: e = {3'd4, 7'b0000111};
      6'd43: e = {3'd3, 7'b0000101};
      6'd44: e = {3'd4, 7'b0000100};
      6'd45: e = {3'd2, 7'b0000011};
      6'd46: e = {3'd2, 7'b0000010};
      6'd47: e = {3'd3, 7'b0000111};
      6'd48: e = {3'd4, 7'b0000110};
      6'd49: e = {3'd4, 7'b0001101};
      6'd50: e = {3'd3, 7'b0000010};
      6'd51: e = {3'd3, 7'b0000000};
      6'd52: e = {3'd1, 7'b0000001};
      6'd53: e = {3'd3, 7'b0000001};
      6'd54: e = {3'd4, 7'b0000001};
      6'd55: e = {3'd3, 7'b0000011};
      6'd56: e = {3'd4, 7'b0001001};
      6'd57: e = {3'd4, 7'b0001011};
      6'd58: e = {3'd4, 7'b0001100};
      6'd63: e = {3'd6, 7'b0001101};
      default: e = 10'd0;
    endcase
    return rom_entry_t'(e);
  endfunction

endpackage

`default_nettype wire

// File: rtl/mte_front.sv
`default_nettype none

module mte_front #(
  parameter int COUNT_BITS = mte_pkg::COUNT_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           text_valid,
  input  wire mte_pkg::text_t text,
  input  wire logic           q_full,
  output mte_pkg::push_t      q_push
);

  logic                  word_start;
  logic [COUNT_BITS-1:0] skip_counter;

  logic                  word_start_next;
  logic [COUNT_BITS-1:0] skip_counter_next;
  logic [COUNT_BITS-1:0] cnt_base;
  logic                  ws_base;
  logic [7:0]            c;
  mte_pkg::rom_entry_t   entry;
  mte_pkg::kind_t        kind;
  logic [31:0]           cnt_wide;

  always_comb begin
    cnt_base = text.start_of_text ? '0 : skip_counter;
    ws_base  = text.start_of_text | word_start;
    c        = text.character;
    if (c >= mte_pkg::CHAR_LOWER_A && c <= mte_pkg::CHAR_LOWER_Z) begin
      c = c - mte_pkg::CASE_OFFSET;
    end
    entry = '0;
    if (c >= mte_pkg::CHAR_SPACE && c <= mte_pkg::CHAR_TOP) begin
      entry = mte_pkg::morse_rom(6'(c - mte_pkg::CHAR_SPACE));
    end
    if (c == mte_pkg::CHAR_SPACE) begin
      kind = mte_pkg::KIND_SPACE;
    end else if (entry.len == 3'd0) begin
      kind = mte_pkg::KIND_SKIP;
    end else begin
      kind = mte_pkg::KIND_CODE;
    end

    skip_counter_next = cnt_base;
    word_start_next   = ws_base;
    unique case (kind)
      mte_pkg::KIND_SPACE: word_start_next = 1'b1;
      mte_pkg::KIND_SKIP: begin
        if (cnt_base != {COUNT_BITS{1'b1}}) begin
          skip_counter_next = cnt_base + 1'b1;
        end
      end
      mte_pkg::KIND_CODE: word_start_next = 1'b0;
      default: word_start_next = ws_base;
    endcase

    cnt_wide = 32'(skip_counter_next);

    q_push.push          = text_valid && !q_full;
    q_push.cmd.kind      = kind;
    q_push.cmd.inter_sym = (kind == mte_pkg::KIND_CODE) && !ws_base;
    q_push.cmd.len       = entry.len;
    q_push.cmd.pattern   = entry.pattern;
    q_push.cmd.shown     = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF
                                                      : cnt_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_start   <= 1'b1;
      skip_counter <= '0;
    end else if (q_push.push) begin
      word_start   <= word_start_next;
      skip_counter <= skip_counter_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mte_queue.sv
`default_nettype none

module mte_queue #(
  parameter int DEPTH = mte_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mte_pkg::push_t q_push,
  input  wire logic          pop,
  output logic               full,
  output logic               q_valid,
  output mte_pkg::cmd_t      q_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  mte_pkg::cmd_t       store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = store[rd_ptr];
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mte_back.sv
`default_nettype none

`include "assert_macros.svh"

module mte_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire mte_pkg::cmd_t q_data,
  output logic               pop,
  output logic               elem_valid,
  input  wire logic          elem_stall,
  output mte_pkg::elem_t     elem
);

  logic          busy;
  logic          pre;
  logic [3:0]    pos;
  mte_pkg::cmd_t cmd;

  logic           out_free;
  logic           last;
  logic [3:0]     lim;
  logic [2:0]     tone_idx;
  logic           is_code;
  mte_pkg::elem_t next_elem;

  assign out_free = !elem_valid || !elem_stall;
  assign pop      = !busy && q_valid;
  assign is_code  = (cmd.kind == mte_pkg::KIND_CODE);

  always_comb begin
    lim      = 4'({cmd.len, 1'b0}) - 4'd2;
    tone_idx = cmd.len - 3'd1 - pos[3:1];
    next_elem.skipped_count = cmd.shown;
    last = 1'b1;
    unique case (cmd.kind)
      mte_pkg::KIND_SPACE: next_elem.element = mte_pkg::EL_INTER_WORD;
      mte_pkg::KIND_SKIP:  next_elem.element = mte_pkg::EL_SKIPPED;
      mte_pkg::KIND_CODE: begin
        if (pre) begin
          next_elem.element = mte_pkg::EL_INTER_SYM;
        end else if (pos[0]) begin
          next_elem.element = mte_pkg::EL_INTRA;
        end else if (cmd.pattern[tone_idx]) begin
          next_elem.element = mte_pkg::EL_DAH;
        end else begin
          next_elem.element = mte_pkg::EL_DIT;
        end
        last = !pre && (pos == lim);
      end
      default: next_elem.element = mte_pkg::EL_SKIPPED;
    endcase
    next_elem.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pre        <= 1'b0;
      pos        <= '0;
      elem_valid <= 1'b0;
    end else begin
      if (out_free) begin
        elem_valid <= busy;
        if (busy) begin
          elem <= next_elem;
          if (last) begin
            busy <= 1'b0;
          end else if (pre) begin
            pre <= 1'b0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
      end
      if (pop) begin
        busy <= 1'b1;
        cmd  <= q_data;
        pre  <= q_data.inter_sym;
        pos  <= '0;
      end
    end
  end

  `ASSERT_CLKED(a_pop_loads, clk, rst, pop |=> busy, "pop did not load the sequencer")
  `ASSERT_CLKED(a_pre_busy, clk, rst, pre |-> busy, "pause pending while idle")
  `ASSERT_CLKED(a_single, clk, rst, busy && !is_code |-> pos == 4'd0 && !pre, "single run advanced")
  `ASSERT_CLKED(a_pos_range, clk, rst, busy && is_code |-> pos <= lim, "position past end of code")

endmodule

`default_nettype wire

// File: rtl/morse_text_encoder.sv
`default_nettype none

// Morse text encoder: each text transaction (one byte, optional start of text)
// becomes a run of one to fourteen element transactions, the last flagged by
// last_of_run. A byte is accepted and queued (two deep); the sequencer then
// loads it from the queue and emits one element per cycle while the output
// is not stalled, and it loads no further byte until the last element of the
// run has been issued. The input is stalled only while the queue is full.
module morse_text_encoder #(
  parameter int COUNT_BITS = mte_pkg::COUNT_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           text_valid,
  output logic                text_stall,
  input  wire mte_pkg::text_t text,
  output logic                elem_valid,
  input  wire logic           elem_stall,
  output mte_pkg::elem_t      elem
);

  mte_pkg::push_t q_push;
  mte_pkg::cmd_t  q_data;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  assign text_stall = q_full;

  mte_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .text_valid(text_valid),
    .text      (text),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  mte_queue #(
    .DEPTH(mte_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .full   (q_full),
    .q_valid(q_valid),
    .q_data (q_data)
  );

  mte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .elem_valid(elem_valid),
    .elem_stall(elem_stall),
    .elem      (elem)
  );

endmodule

`default_nettype wire

// File: tb/tb_morse_text_encoder.sv
module tb_morse_text_encoder;
  import mte_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int REPORT_CAP  = 100;
  localparam int RAND_ITEMS  = 320;

  typedef struct packed {
    logic  settle;
    text_t payload;
  } text_job_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  text_valid = 1'b0;
  logic  text_stall;
  text_t text = '0;
  logic  elem_valid;
  logic  elem_stall = 1'b0;
  elem_t elem;

  text_job_t text_backlog[$];
  elem_t     predicted_elems[$];
  text_job_t next_job;

  logic                  at_word_start = 1'b1;
  logic [COUNT_BITS-1:0] skip_tally = '0;

  int    fails = 0;
  int    cycles = 0;
  elem_t want;

  morse_text_encoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .elem       (elem)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic string tones_of(input logic [7:0] c);
    case (c)
      8'd33: return "-.-.--";
      8'd34: return ".-..-.";
      8'd36: return "...-..-";
      8'd38: return ".-...";
      8'd39: return ".----.";
      8'd40: return "-.--.";
      8'd41: return "-.--.-";
      8'd43: return ".-.-.";
      8'd44: return "--..--";
      8'd45: return "-....-";
      8'd46: return ".-.-.-";
      8'd47: return "-..-.";
      8'd48: return "-----";
      8'd49: return ".----";
      8'd50: return "..---";
      8'd51: return "...--";
      8'd52: return "....-";
      8'd53: return ".....";
      8'd54: return "-....";
      8'd55: return "--...";
      8'd56: return "---..";
      8'd57: return "----.";
      8'd58: return "---...";
      8'd59: return "-.-.-.";
      8'd61: return "-...-";
      8'd63: return "..--..";
      8'd64: return ".--.-.";
      8'd65: return ".-";
      8'd66: return "-...";
      8'd67: return "-.-.";
      8'd68: return "-..";
      8'd69: return ".";
      8'd70: return "..-.";
      8'd71: return "--.";
      8'd72: return "....";
      8'd73: return "..";
      8'd74: return ".---";
      8'd75: return "-.-";
      8'd76: return ".-..";
      8'd77: return "--";
      8'd78: return "-.";
      8'd79: return "---";
      8'd80: return ".--.";
      8'd81: return "--.-";
      8'd82: return ".-.";
      8'd83: return "...";
      8'd84: return "-";
      8'd85: return "..-";
      8'd86: return "...-";
      8'd87: return ".--";
      8'd88: return "-..-";
      8'd89: return "-.--";
      8'd90: return "--..";
      8'd95: return "..--.-";
      default: return "";
    endcase
  endfunction

  task automatic encode_char(input text_t t);
    logic [7:0]  c;
    string       seq;
    logic [2:0]  run[$];
    logic [63:0] wide;
    logic [15:0] shown;
    elem_t       e;
    int          i;
    if (t.start_of_text) begin
      skip_tally    = '0;
      at_word_start = 1'b1;
    end
    c = t.character;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      c = c - CASE_OFFSET;
    end
    if (c == CHAR_SPACE) begin
      run.push_back(EL_INTER_WORD);
      at_word_start = 1'b1;
    end else begin
      seq = tones_of(c);
      if (seq.len() == 0) begin
        if (skip_tally != '1) begin
          skip_tally = skip_tally + 1'b1;
        end
        run.push_back(EL_SKIPPED);
      end else begin
        if (at_word_start) begin
          at_word_start = 1'b0;
        end else begin
          run.push_back(EL_INTER_SYM);
        end
        for (i = 0; i < seq.len(); i++) begin
          if (i > 0) begin
            run.push_back(EL_INTRA);
          end
          run.push_back(seq[i] == "-" ? EL_DAH : EL_DIT);
        end
      end
    end
    wide  = 64'(skip_tally);
    shown = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
    for (i = 0; i < run.size(); i++) begin
      e.element       = run[i];
      e.last_of_run   = (i == run.size() - 1);
      e.skipped_count = shown;
      predicted_elems.push_back(e);
    end
  endtask

  task automatic add_job(input logic [7:0] c, input logic sot, input logic settle);
    text_job_t j;
    j.settle                = settle;
    j.payload.character     = c;
    j.payload.start_of_text = sot;
    text_backlog.push_back(j);
  endtask

  task automatic note_fault(input string what, input elem_t exp_e, input elem_t got_e);
    if (fails < REPORT_CAP) begin
      $display("%0t: %s expected el=%0d last=%0b cnt=%0d, actual el=%0d last=%0b cnt=%0d",
               $time, what, exp_e.element, exp_e.last_of_run, exp_e.skipped_count,
               got_e.element, got_e.last_of_run, got_e.skipped_count);
    end
    fails++;
  endtask

  function automatic logic quiet_stretch();
    return text_backlog.size() >= 100 && text_backlog.size() < 200;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        encode_char(text);
      end
      if (!text_valid || !text_stall) begin
        if (text_backlog.size() > 0
            && !(text_backlog[0].settle && predicted_elems.size() > 0)
            && (quiet_stretch() || $urandom_range(99) >= 15)) begin
          next_job = text_backlog.pop_front();
          text_valid <= 1'b1;
          text       <= next_job.payload;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      elem_stall <= 1'b0;
    end else begin
      if (elem_valid && !elem_stall) begin
        if (predicted_elems.size() == 0) begin
          note_fault("unexpected transaction:", '0, elem);
        end else begin
          want = predicted_elems.pop_front();
          if (elem.element !== want.element || elem.last_of_run !== want.last_of_run
              || elem.skipped_count !== want.skipped_count) begin
            note_fault("mismatch:", want, elem);
          end
        end
      end
      elem_stall <= !quiet_stretch() && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_morse_text_encoder: FAIL");
      $finish;
    end
  end

  initial begin
    int         i;
    int         r;
    logic [7:0] c;

    add_job("A", 1'b1, 1'b0);
    add_job("a", 1'b0, 1'b0);
    add_job("z", 1'b0, 1'b0);
    add_job("Z", 1'b0, 1'b0);
    add_job("$", 1'b0, 1'b0);
    add_job(" ", 1'b0, 1'b0);
    add_job("_", 1'b0, 1'b0);
    add_job("^", 1'b0, 1'b0);
    add_job(8'd0, 1'b0, 1'b0);
    add_job(8'd10, 1'b0, 1'b0);
    add_job(8'd255, 1'b0, 1'b0);
    add_job(8'd96, 1'b0, 1'b0);
    add_job(8'd123, 1'b0, 1'b0);
    add_job(8'd127, 1'b0, 1'b0);
    add_job(8'd128, 1'b0, 1'b0);
    add_job("0", 1'b0, 1'b0);
    add_job("9", 1'b0, 1'b0);
    add_job("?", 1'b0, 1'b0);
    add_job("E", 1'b0, 1'b0);
    add_job(" ", 1'b0, 1'b0);
    add_job(" ", 1'b0, 1'b0);
    add_job("#", 1'b1, 1'b0);
    add_job("E", 1'b1, 1'b0);
    add_job(".", 1'b0, 1'b0);
    add_job("-", 1'b0, 1'b0);
    add_job("^", 1'b0, 1'b0);
    add_job("E", 1'b0, 1'b0);
    add_job(" ", 1'b0, 1'b0);
    add_job(8'd0, 1'b0, 1'b0);

    for (i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        c = 8'(65 + $urandom_range(25));
        if ($urandom_range(1)) begin
          c = c + CASE_OFFSET;
        end
      end else if (r < 50) begin
        c = 8'(48 + $urandom_range(9));
      end else if (r < 62) begin
        c = CHAR_SPACE;
      end else if (r < 80) begin
        c = 8'($urandom_range(95, 32));
      end else begin
        c = 8'($urandom_range(255));
      end
      add_job(c, i == 0 || $urandom_range(99) < 4, i == 0 || i == 200);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (text_backlog.size() > 0 || text_valid) @(posedge clk);
    while (predicted_elems.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fails == 0) begin
      $display("tb_morse_text_encoder: PASS");
    end else begin
      $display("tb_morse_text_encoder: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mte_pkg.sv
rtl/mte_front.sv
rtl/mte_queue.sv
rtl/mte_back.sv
rtl/morse_text_encoder.sv
tb/tb_morse_text_encoder.sv
